@@ hw/rtl/arp_cache_resolver_assert.svh @@
// Assertion macros shared by the ARP cache resolver RTL.
`ifndef ARP_CACHE_RESOLVER_ASSERT_SVH
`define ARP_CACHE_RESOLVER_ASSERT_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define ARPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and held off during reset.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/arpc_pkg.sv @@
// Shared types and constants of the ARP cache resolver.
`timescale 1ns / 1ps

package arpc_pkg;

    // Field widths.
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int FIELD16_W = 16;
    localparam int LEN_W     = 11;
    localparam int ENTRY_W   = IP_W + MAC_W;

    // Protocol constants.
    localparam logic [FIELD16_W-1:0] HW_ETHERNET = 16'h0001;
    localparam logic [FIELD16_W-1:0] PROTO_IPV4  = 16'h0800;
    localparam logic [FIELD16_W-1:0] OP_REQUEST  = 16'h0001;
    localparam logic [LEN_W-1:0]     MIN_ARP_LEN = 11'd28;

    // Item kinds.
    localparam logic OPC_RESOLVE = 1'b0;
    localparam logic OPC_PACKET  = 1'b1;

    // Register word index of our_ip.
    localparam logic REG_OUR_IP = 1'b0;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_RESOLVED = 2'd1,
        ACT_REQUEST  = 2'd2,
        ACT_REPLY    = 2'd3
    } arpc_action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESULT
    } arpc_state_t;

    // Result handed from the lookup engine to the output stage.
    typedef struct packed {
        arpc_action_t            action;
        logic [MAC_W-1:0]        mac;
        logic [IP_W-1:0]         ip;
    } arpc_result_t;

endpackage

@@ hw/rtl/arpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module arpc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/arpc_regs.sv @@
// APB-style configuration register holding the local IP address.
`timescale 1ns / 1ps

module arpc_regs import arpc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output logic [IP_W-1:0] our_ip
);

    logic [IP_W-1:0] our_ip_reg;
    logic [IP_W-1:0] our_ip_next;
    logic            wr_hit;

    // A write lands in the access phase when the word address matches.
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_OUR_IP);

    always_comb begin
        our_ip_next = our_ip_reg;
        if (wr_hit) begin
            our_ip_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            our_ip_reg <= '0;
        end else begin
            our_ip_reg <= our_ip_next;
        end
    end

    // Read back; addresses past the register return zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_OUR_IP) begin
            prdata = our_ip_reg;
        end
    end

    assign pready = 1'b1;
    assign our_ip = our_ip_reg;

endmodule

@@ hw/rtl/arpc_engine.sv @@
// Lookup engine: scans the entry memory, updates it and forms one result per request.
`timescale 1ns / 1ps

module arpc_engine import arpc_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [IP_W-1:0]      s_ip_address,
    input  logic [MAC_W-1:0]     s_mac_address,
    input  logic [IP_W-1:0]      s_target_ip,
    input  logic [FIELD16_W-1:0] s_hardware_type,
    input  logic [FIELD16_W-1:0] s_protocol_type,
    input  logic [FIELD16_W-1:0] s_arp_operation,
    input  logic [LEN_W-1:0]     s_payload_length,
    input  logic [IP_W-1:0]      our_ip,
    output logic                 res_valid,
    input  logic                 res_ready,
    output arpc_result_t         res
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    arpc_state_t state_reg, state_next;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                     hit_reg, hit_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic [MAC_W-1:0]         hit_mac_reg, hit_mac_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;

    logic                     item_opcode_reg, item_opcode_next;
    logic [IP_W-1:0]          item_ip_reg, item_ip_next;
    logic [MAC_W-1:0]         item_mac_reg, item_mac_next;
    logic                     item_reply_reg, item_reply_next;
    logic                     item_drop_reg, item_drop_next;

    logic                     accept;
    logic                     pkt_good;
    logic                     last_scan;
    logic [ENTRY_W-1:0]       rd_data;
    logic [IP_W-1:0]          rd_ip;
    logic [MAC_W-1:0]         rd_mac;
    logic                     hit_now;
    logic                     free_now;
    logic                     ram_we;
    logic [IDX_W-1:0]         wr_slot;

    // Entry memory: IP in the upper bits, MAC in the lower bits.
    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_entry_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(wr_slot),
        .wr_data({item_ip_reg, item_mac_reg}),
        .rd_addr(scan_idx_reg),
        .rd_data(rd_data)
    );

    assign rd_ip  = rd_data[ENTRY_W-1 -: IP_W];
    assign rd_mac = rd_data[MAC_W-1:0];

    assign accept    = s_valid && s_ready;
    assign last_scan = (scan_idx_reg == LAST_IDX);
    assign pkt_good  = (s_payload_length >= MIN_ARP_LEN) &&
                       (s_hardware_type == HW_ETHERNET) &&
                       (s_protocol_type == PROTO_IPV4);

    // Compare stage, working on the read address of the previous cycle.
    assign hit_now  = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_ip == item_ip_reg);
    assign free_now = cmp_valid_reg && !valid_reg[cmp_idx_reg];

    // Slot to write: matching entry, else lowest free slot, else slot zero.
    always_comb begin
        if (hit_reg) begin
            wr_slot = hit_idx_reg;
        end else if (free_found_reg) begin
            wr_slot = free_idx_reg;
        end else begin
            wr_slot = '0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == OPC_PACKET && !pkt_good) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (last_scan) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (item_opcode_reg == OPC_PACKET) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_UPDATE: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State-driven outputs.
    always_comb begin
        s_ready   = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready   = 1'b1;
            ST_SCAN:   ;
            ST_DRAIN:  ;
            ST_UPDATE: ram_we    = 1'b1;
            ST_RESULT: res_valid = 1'b1;
            default:   ;
        endcase
    end

    // Result fields from the captured request and the scan outcome.
    always_comb begin
        res.action = ACT_NONE;
        res.mac    = '0;
        res.ip     = '0;
        if (item_opcode_reg == OPC_RESOLVE) begin
            if (hit_reg) begin
                res.action = ACT_RESOLVED;
                res.mac    = hit_mac_reg;
            end else begin
                res.action = ACT_REQUEST;
                res.ip     = item_ip_reg;
            end
        end else if (!item_drop_reg && item_reply_reg) begin
            res.action = ACT_REPLY;
            res.mac    = item_mac_reg;
            res.ip     = item_ip_reg;
        end
    end

    // Request capture, scan counter and match tracking.
    always_comb begin
        item_opcode_next = item_opcode_reg;
        item_ip_next     = item_ip_reg;
        item_mac_next    = item_mac_reg;
        item_reply_next  = item_reply_reg;
        item_drop_next   = item_drop_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = (state_reg == ST_SCAN);
        cmp_idx_next     = scan_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_mac_next     = hit_mac_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        valid_next       = valid_reg;

        if (accept) begin
            item_opcode_next = s_opcode;
            item_ip_next     = s_ip_address;
            item_mac_next    = s_mac_address;
            item_reply_next  = (s_arp_operation == OP_REQUEST) && (s_target_ip == our_ip);
            item_drop_next   = (s_opcode == OPC_PACKET) && !pkt_good;
            scan_idx_next    = '0;
            hit_next         = 1'b0;
            free_found_next  = 1'b0;
        end

        if (state_reg == ST_SCAN && !last_scan) begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        // Keep the lowest matching slot and the lowest free slot.
        if (hit_now && !hit_reg) begin
            hit_next     = 1'b1;
            hit_idx_next = cmp_idx_reg;
            hit_mac_next = rd_mac;
        end
        if (free_now && !free_found_reg) begin
            free_found_next = 1'b1;
            free_idx_next   = cmp_idx_reg;
        end

        if (ram_we) begin
            valid_next[wr_slot] = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        item_opcode_reg <= item_opcode_next;
        item_ip_reg     <= item_ip_next;
        item_mac_reg    <= item_mac_next;
        item_reply_reg  <= item_reply_next;
        item_drop_reg   <= item_drop_next;
        cmp_idx_reg     <= cmp_idx_next;
        hit_idx_reg     <= hit_idx_next;
        hit_mac_reg     <= hit_mac_next;
        free_idx_reg    <= free_idx_next;
    end

endmodule

@@ hw/rtl/arp_cache_resolver.sv @@
// Top level of the ARP cache resolver: config port, lookup engine and output register.
//
//   Channel   Direction  Handshake          Moves
//   s_        in         s_valid/s_ready    one request: resolve query or received ARP packet
//   m_        out        m_valid/m_ready    one result per request
//   APB       in         psel/penable       write or read of our_ip
//
// A query holds the engine from acceptance to the next ready cycle: a one-entry-per-cycle
// scan over the entry memory's read port, a drain step and the result state (a well-formed
// packet adds a write-back step). A dropped packet skips the scan and goes to the result.
// One request is in the engine at a time.
// Reset clears the valid marks and our_ip at once; no clearing pass is needed.
// A waiting result holds in the output register while the engine takes the next request.
`timescale 1ns / 1ps

module arp_cache_resolver import arpc_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Request channel.
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [IP_W-1:0]      s_ip_address,
    input  logic [MAC_W-1:0]     s_mac_address,
    input  logic [IP_W-1:0]      s_target_ip,
    input  logic [FIELD16_W-1:0] s_hardware_type,
    input  logic [FIELD16_W-1:0] s_protocol_type,
    input  logic [FIELD16_W-1:0] s_arp_operation,
    input  logic [LEN_W-1:0]     s_payload_length,
    // Result channel.
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_action,
    output logic [MAC_W-1:0]     m_result_mac,
    output logic [IP_W-1:0]      m_result_ip
);

`include "arp_cache_resolver_assert.svh"

    logic [IP_W-1:0] our_ip;
    logic            res_valid;
    logic            res_ready;
    arpc_result_t    res;

    logic            m_valid_reg, m_valid_next;
    arpc_result_t    m_res_reg, m_res_next;
    logic            m_request;

    arpc_regs u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .our_ip (our_ip)
    );

    arpc_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_ip_address    (s_ip_address),
        .s_mac_address   (s_mac_address),
        .s_target_ip     (s_target_ip),
        .s_hardware_type (s_hardware_type),
        .s_protocol_type (s_protocol_type),
        .s_arp_operation (s_arp_operation),
        .s_payload_length(s_payload_length),
        .our_ip          (our_ip),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    // Output register takes a new result when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = m_res_reg.action;
    assign m_result_mac = m_res_reg.mac;
    assign m_result_ip  = m_res_reg.ip;

    // A result on the output that asks for an ARP request.
    assign m_request = m_valid && (m_action == ACT_REQUEST);

    // The engine works on one request at a time.
    `ARPC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "second request taken")
    // An idle engine has no result pending.
    `ARPC_ASSERT_SAME(a_idle_no_result, s_ready, !res_valid, "result offered while idle")
    // A result handed over shows up at the output on the next cycle.
    `ARPC_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_valid, "result was lost")
    // A miss asks for a request and carries no MAC.
    `ARPC_ASSERT_SAME(a_request_no_mac, m_request, m_result_mac == '0, "request carries a MAC")

endmodule

@@ sim/arp_cache_checker.sv @@
// Checker for the ARP cache resolver: mirrors the cache, predicts each result and compares.
`timescale 1ns / 1ps

module arp_cache_checker import arpc_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration port, watched only.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic [31:0]          prdata,
    input  logic                 pready,
    // Request channel.
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [IP_W-1:0]      s_ip_address,
    input  logic [MAC_W-1:0]     s_mac_address,
    input  logic [IP_W-1:0]      s_target_ip,
    input  logic [FIELD16_W-1:0] s_hardware_type,
    input  logic [FIELD16_W-1:0] s_protocol_type,
    input  logic [FIELD16_W-1:0] s_arp_operation,
    input  logic [LEN_W-1:0]     s_payload_length,
    // Result channel.
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [1:0]           m_action,
    input  logic [MAC_W-1:0]     m_result_mac,
    input  logic [IP_W-1:0]      m_result_ip,
    // Totals handed to the testbench top.
    output int                   fail_count,
    output int                   pending,
    output int                   hit_count,
    output int                   miss_count,
    output int                   reply_count,
    output int                   silent_count
);

    localparam logic [2:0] OUR_IP_ADDR  = {REG_OUR_IP, 2'b00};
    localparam int         REPORT_LIMIT = 10;

    // Mirror of the cache and of the local address.
    logic [IP_W-1:0]  our_ip_copy;
    logic             cache_valid [TABLE_ENTRIES];
    logic [IP_W-1:0]  cache_ip    [TABLE_ENTRIES];
    logic [MAC_W-1:0] cache_mac   [TABLE_ENTRIES];

    // Results owed by the block, oldest first.
    arpc_result_t     awaited_results [$];
    int               results_seen;

    // Lowest valid slot that holds this IP, or -1 on a miss.
    function automatic int find_slot(input logic [IP_W-1:0] ip);
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (cache_valid[i] && cache_ip[i] == ip) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Refresh a known sender, else fill the lowest free slot, else overwrite slot 0.
    function automatic void learn_sender(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        int slot;
        int i;
        slot = find_slot(ip);
        if (slot < 0) begin
            slot = 0;
            for (i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                if (!cache_valid[i]) begin
                    slot = i;
                end
            end
            cache_ip[slot]    = ip;
            cache_valid[slot] = 1'b1;
        end
        cache_mac[slot] = mac;
    endfunction

    // Work out the result of one request and apply its effect on the cache.
    function automatic arpc_result_t resolve_request(
        input logic                 opcode,
        input logic [IP_W-1:0]      ip,
        input logic [MAC_W-1:0]     mac,
        input logic [IP_W-1:0]      tip,
        input logic [FIELD16_W-1:0] hw,
        input logic [FIELD16_W-1:0] proto,
        input logic [FIELD16_W-1:0] op,
        input logic [LEN_W-1:0]     len
    );
        arpc_result_t r;
        int           slot;
        r.action = ACT_NONE;
        r.mac    = '0;
        r.ip     = '0;
        if (opcode == OPC_RESOLVE) begin
            slot = find_slot(ip);
            if (slot >= 0) begin
                r.action = ACT_RESOLVED;
                r.mac    = cache_mac[slot];
            end else begin
                r.action = ACT_REQUEST;
                r.ip     = ip;
            end
        end else if (len >= MIN_ARP_LEN && hw == HW_ETHERNET && proto == PROTO_IPV4) begin
            learn_sender(ip, mac);
            if (op == OP_REQUEST && tip == our_ip_copy) begin
                r.action = ACT_REPLY;
                r.mac    = mac;
                r.ip     = ip;
            end
        end
        return r;
    endfunction

    // Count a failure; only the first few are described.
    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] MISMATCH %s", $realtime, what);
        end
    endtask

    // Watch both channels and the configuration port at every rising edge.
    always @(posedge aclk) begin : watch
        arpc_result_t want;
        int           i;
        if (!aresetn) begin
            our_ip_copy = '0;
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                cache_valid[i] = 1'b0;
            end
            awaited_results.delete();
            results_seen = 0;
            fail_count   = 0;
            hit_count    = 0;
            miss_count   = 0;
            reply_count  = 0;
            silent_count = 0;
        end else begin
            // A result leaving the block is matched against the oldest request.
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with no request outstanding",
                                           results_seen));
                end else begin
                    want = awaited_results.pop_front();
                    if (want.action !== m_action || want.mac !== m_result_mac ||
                        want.ip !== m_result_ip) begin
                        note_failure($sformatf(
                            "result %0d: expected action %0d mac %h ip %h, got action %0d mac %h ip %h",
                            results_seen, want.action, want.mac, want.ip,
                            m_action, m_result_mac, m_result_ip));
                    end else begin
                        case (want.action)
                            ACT_RESOLVED: hit_count++;
                            ACT_REQUEST:  miss_count++;
                            ACT_REPLY:    reply_count++;
                            default:      silent_count++;
                        endcase
                    end
                end
            end

            // An accepted request is predicted right away.
            if (s_valid && s_ready) begin
                awaited_results.push_back(resolve_request(
                    s_opcode, s_ip_address, s_mac_address, s_target_ip,
                    s_hardware_type, s_protocol_type, s_arp_operation, s_payload_length));
            end

            // Track writes of the local address and check read-backs.
            if (psel && penable && pready && paddr == OUR_IP_ADDR) begin
                if (pwrite) begin
                    our_ip_copy = pwdata;
                end else if (prdata !== our_ip_copy) begin
                    note_failure($sformatf("our_ip read-back: expected %h, got %h",
                                           our_ip_copy, prdata));
                end
            end
        end
        pending = awaited_results.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for the ARP cache resolver: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb import arpc_pkg::*; ();

    localparam int                   TABLE_ENTRIES = 16;
    localparam int                   POOL_SIZE     = 20;
    localparam int                   PHASE_ITEMS   = 325;
    localparam int                   HOLD_CYCLES   = 300;
    localparam int                   STALL_LIMIT   = 4000;
    localparam int                   DRAIN_CYCLES  = TABLE_ENTRIES + 8;
    localparam int                   IDLE_PERCENT  = 12;
    localparam logic [2:0]           OUR_IP_ADDR   = {REG_OUR_IP, 2'b00};
    localparam logic [FIELD16_W-1:0] OP_REPLY      = 16'h0002;

    typedef struct packed {
        logic                 opcode;
        logic [IP_W-1:0]      ip_address;
        logic [MAC_W-1:0]     mac_address;
        logic [IP_W-1:0]      target_ip;
        logic [FIELD16_W-1:0] hardware_type;
        logic [FIELD16_W-1:0] protocol_type;
        logic [FIELD16_W-1:0] arp_operation;
        logic [LEN_W-1:0]     payload_length;
    } arp_request_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_opcode;
    logic [IP_W-1:0]      s_ip_address;
    logic [MAC_W-1:0]     s_mac_address;
    logic [IP_W-1:0]      s_target_ip;
    logic [FIELD16_W-1:0] s_hardware_type;
    logic [FIELD16_W-1:0] s_protocol_type;
    logic [FIELD16_W-1:0] s_arp_operation;
    logic [LEN_W-1:0]     s_payload_length;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_action;
    logic [MAC_W-1:0]     m_result_mac;
    logic [IP_W-1:0]      m_result_ip;

    int                   fail_count;
    int                   pending;
    int                   hit_count;
    int                   miss_count;
    int                   reply_count;
    int                   silent_count;

    // Stimulus state shared with the pacing processes.
    logic [IP_W-1:0]      cur_our_ip;
    logic [IP_W-1:0]      ip_pool [POOL_SIZE];
    logic                 no_idle;
    int                   holds_asked;
    int                   sent_count;
    int                   setting_count;

    arp_cache_resolver #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_ip_address    (s_ip_address),
        .s_mac_address   (s_mac_address),
        .s_target_ip     (s_target_ip),
        .s_hardware_type (s_hardware_type),
        .s_protocol_type (s_protocol_type),
        .s_arp_operation (s_arp_operation),
        .s_payload_length(s_payload_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_result_mac    (m_result_mac),
        .m_result_ip     (m_result_ip)
    );

    arp_cache_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_ip_address    (s_ip_address),
        .s_mac_address   (s_mac_address),
        .s_target_ip     (s_target_ip),
        .s_hardware_type (s_hardware_type),
        .s_protocol_type (s_protocol_type),
        .s_arp_operation (s_arp_operation),
        .s_payload_length(s_payload_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_result_mac    (m_result_mac),
        .m_result_ip     (m_result_ip),
        .fail_count      (fail_count),
        .pending         (pending),
        .hit_count       (hit_count),
        .miss_count      (miss_count),
        .reply_count     (reply_count),
        .silent_count    (silent_count)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Resolve query; the packet fields are don't-care and get random contents.
    function automatic arp_request_t resolve_query(input logic [IP_W-1:0] ip);
        arp_request_t r;
        r.opcode         = OPC_RESOLVE;
        r.ip_address     = ip;
        r.mac_address    = {16'($urandom()), 32'($urandom())};
        r.target_ip      = $urandom();
        r.hardware_type  = 16'($urandom());
        r.protocol_type  = 16'($urandom());
        r.arp_operation  = 16'($urandom());
        r.payload_length = 11'($urandom());
        return r;
    endfunction

    // Received ARP packet; header fields default to a well-formed one.
    function automatic arp_request_t arp_packet(
        input logic [IP_W-1:0]      ip,
        input logic [MAC_W-1:0]     mac,
        input logic [IP_W-1:0]      tip,
        input logic [FIELD16_W-1:0] op,
        input logic [LEN_W-1:0]     len,
        input logic [FIELD16_W-1:0] hw    = HW_ETHERNET,
        input logic [FIELD16_W-1:0] proto = PROTO_IPV4
    );
        arp_request_t r;
        r.opcode         = OPC_PACKET;
        r.ip_address     = ip;
        r.mac_address    = mac;
        r.target_ip      = tip;
        r.hardware_type  = hw;
        r.protocol_type  = proto;
        r.arp_operation  = op;
        r.payload_length = len;
        return r;
    endfunction

    // Mostly well-formed traffic over a small set of IPs, so the cache hits, refreshes
    // and overflows; the rest is malformed packets and stray addresses.
    function automatic arp_request_t random_request();
        arp_request_t     r;
        logic [IP_W-1:0]  ip;
        logic [FIELD16_W-1:0] op;
        int               roll;
        ip = ($urandom_range(99) < 85) ? ip_pool[$urandom_range(POOL_SIZE - 1)] : $urandom();
        if ($urandom_range(99) < 40) begin
            r = resolve_query(ip);
        end else begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                op = OP_REQUEST;
            end else if (roll < 85) begin
                op = OP_REPLY;
            end else begin
                op = 16'($urandom());
            end
            r = arp_packet(ip, {16'($urandom()), 32'($urandom())},
                           ($urandom_range(99) < 45) ? cur_our_ip : 32'($urandom()),
                           op, 11'($urandom_range(2047, 28)));
            if ($urandom_range(99) < 20) begin
                case ($urandom_range(3))
                    0: r.payload_length = 11'($urandom_range(27));
                    1: r.hardware_type  = 16'($urandom());
                    2: r.protocol_type  = 16'($urandom());
                    default: begin
                        r.hardware_type  = 16'($urandom());
                        r.protocol_type  = 16'($urandom());
                        r.payload_length = 11'($urandom());
                    end
                endcase
            end
        end
        return r;
    endfunction

    // New address set for a phase; more addresses than slots so the cache overflows.
    task automatic refill_pool();
        int i;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        ip_pool[2] = cur_our_ip;
        for (i = 3; i < POOL_SIZE; i++) begin
            ip_pool[i] = $urandom();
        end
    endtask

    // Offer one request, with random gaps before it, and return once it is taken.
    task automatic send_request(input arp_request_t req);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= req.opcode;
        s_ip_address     <= req.ip_address;
        s_mac_address    <= req.mac_address;
        s_target_ip      <= req.target_ip;
        s_hardware_type  <= req.hardware_type;
        s_protocol_type  <= req.protocol_type;
        s_arp_operation  <= req.arp_operation;
        s_payload_length <= req.payload_length;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    // Write our_ip, then read it back so the checker can compare.
    task automatic write_our_ip(input logic [IP_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= OUR_IP_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_our_ip = value;
        setting_count++;
    endtask

    // One random phase under a fresh our_ip, written once the block has drained.
    task automatic run_random_phase(input logic [IP_W-1:0] our_ip_value, input bit with_hold);
        int n;
        while (pending != 0) @(negedge aclk);
        write_our_ip(our_ip_value);
        refill_pool();
        if (with_hold) begin
            holds_asked <= holds_asked + 1;
        end
        for (n = 0; n < PHASE_ITEMS; n++) begin
            no_idle <= with_hold && n >= 120 && n < 260;
            send_request(random_request());
        end
        s_valid <= 1'b0;
        no_idle <= 1'b0;
    endtask

    // Result side pacing: random back-pressure, plus a long hold-off when asked.
    initial begin : result_pacing
        int holds_done;
        holds_done = 0;
        m_ready    = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (holds_done < holds_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
                @(negedge aclk);
            end
        end
    end

    // End the run if neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no request or result moved for %0d cycles.", STALL_LIMIT);
        $display("arp_cache_resolver regression: fail");
        $finish;
    end

    // Reset, directed requests, random phases and the verdict.
    initial begin : stimulus
        aresetn          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_valid          = 1'b0;
        s_opcode         = OPC_RESOLVE;
        s_ip_address     = '0;
        s_mac_address    = '0;
        s_target_ip      = '0;
        s_hardware_type  = '0;
        s_protocol_type  = '0;
        s_arp_operation  = '0;
        s_payload_length = '0;
        cur_our_ip       = '0;
        no_idle          = 1'b0;
        holds_asked      = 0;
        sent_count       = 0;
        setting_count    = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with our_ip at zero: misses on an empty cache, learning,
        // refresh, replies to requests for our address, and every drop reason.
        write_our_ip('0);
        send_request(resolve_query(32'h0000_0000));
        send_request(resolve_query(32'hFFFF_FFFF));
        send_request(arp_packet(32'hC0A8_0001, 48'h0, 32'h0A00_0001, OP_REPLY, 11'd28));
        send_request(resolve_query(32'hC0A8_0001));
        send_request(arp_packet(32'hC0A8_0001, '1, 32'h0000_0000, OP_REQUEST, 11'd2047));
        send_request(resolve_query(32'hC0A8_0001));
        send_request(arp_packet(32'hC0A8_0002, 48'h0200_0000_0002, 32'h0, OP_REQUEST, 11'd27));
        send_request(resolve_query(32'hC0A8_0002));
        send_request(arp_packet(32'hC0A8_0002, 48'h0200_0000_0002, 32'h0, OP_REQUEST, 11'd0));
        send_request(arp_packet(32'hC0A8_0003, 48'h0200_0000_0003, 32'h0, OP_REQUEST,
                                11'd64, 16'h0000));
        send_request(arp_packet(32'hC0A8_0003, 48'h0200_0000_0003, 32'h0, OP_REQUEST,
                                11'd64, 16'hFFFF));
        send_request(arp_packet(32'hC0A8_0003, 48'h0200_0000_0003, 32'h0, OP_REQUEST,
                                11'd64, HW_ETHERNET, 16'h0806));
        send_request(arp_packet(32'hC0A8_0003, 48'h0200_0000_0003, 32'h0, OP_REQUEST,
                                11'd64, HW_ETHERNET, 16'hFFFF));
        send_request(arp_packet(32'hC0A8_0003, 48'h0200_0000_0003, 32'h0, OP_REQUEST,
                                11'd64, HW_ETHERNET, 16'h0000));
        send_request(resolve_query(32'hC0A8_0003));
        send_request(arp_packet(32'hFFFF_FFFF, 48'hA5A5_5A5A_F00F, 32'h0000_0001,
                                OP_REQUEST, 11'd28));
        send_request(arp_packet(32'h0A0A_0A0A, 48'h0000_0000_0001, 32'h0, 16'hFFFF, 11'd28));
        send_request(arp_packet(32'h0A0A_0A0B, 48'h8000_0000_0000, 32'h0, 16'h0000, 11'd28));
        send_request(arp_packet(32'h0000_0000, 48'h1234_5678_9ABC, 32'h0, OP_REQUEST, 11'd100));
        send_request(resolve_query(32'h0000_0000));
        send_request(resolve_query(32'hFFFF_FFFF));
        send_request(resolve_query(32'h0A0A_0A0B));
        s_valid <= 1'b0;

        // Random phases; our_ip goes to all ones, then random values.
        run_random_phase(32'hFFFF_FFFF, 1'b0);
        run_random_phase($urandom(), 1'b0);
        run_random_phase($urandom(), 1'b1);
        run_random_phase($urandom(), 1'b0);

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d requests under %0d our_ip settings, with one long result hold-off.",
                 sent_count, setting_count);
        $display("Results checked: %0d hits, %0d misses, %0d replies, %0d without action.",
                 hit_count, miss_count, reply_count, silent_count);
        if (fail_count == 0 && pending == 0) begin
            $display("arp_cache_resolver regression: pass");
        end else begin
            $display("%0d failures, %0d results still outstanding.", fail_count, pending);
            $display("arp_cache_resolver regression: fail");
        end
        $finish;
    end

endmodule
